>>> hdl/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg: frequent items counter shared definitions
// Sizes and command codes for the heavy-hitter table.
// ----------------------------------------------------------------------------
package fic_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned KeyW = 32;
  localparam int unsigned CntW = 32;
  localparam int unsigned CfgW = 5;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic CmdAdd = 1'b0;
  localparam logic CmdEst = 1'b1;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [KeyW-1:0] key_t;
endpackage

>>> hdl/frequent_items_counter.sv
// ----------------------------------------------------------------------------
// frequent_items_counter: Misra-Gries frequent items table
// The result strobe (done) follows the scan and any decrement sweep.
// A new request is accepted only when idle; a scan reads the memories
// one slot per cycle, with slot 0 read once more at the start.
// Add on a full table then runs a decrement sweep over the slots.
// Reset clears valid bits, totals; sets limit 16; receiver never stalls.
// ----------------------------------------------------------------------------
module frequent_items_counter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_data_i,
  input  logic                 cmd_i,
  input  logic [31:0]          item_key_i,
  output logic                 done,
  output logic [31:0]          lower_count_o,
  output logic [31:0]          upper_count_o,
  output logic [31:0]          items_seen_o,
  output logic [31:0]          error_total_o
);
  import fic_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDec  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CfgW-1:0] lim_cfg_q;
  logic [Slots-1:0] valid_q;
  cnt_t total_q, err_q, lower_q;
  logic cmd_q;
  key_t key_q;
  logic [SlotW:0] idx_q;
  logic rd_vld_q;
  logic [SlotW-1:0] rd_idx_q;
  logic hit_q;
  logic [SlotW-1:0] hit_idx_q;
  cnt_t hit_cnt_q;

  key_t keys_mem [Slots];
  cnt_t cnt_mem [Slots];
  key_t rd_key_q;
  cnt_t rd_cnt_q;

  logic mem_we;
  logic [SlotW-1:0] wr_idx;
  logic key_we;
  cnt_t wr_cnt;
  logic [SlotW-1:0] rd_addr;

  logic [SlotW:0] limit;
  logic [SlotW:0] held;
  logic free_ok;
  logic [SlotW-1:0] free_idx;

  always_comb begin
    priority if (lim_cfg_q == '0) begin
      limit = (SlotW+1)'(1);
    end else if (32'(lim_cfg_q) > Slots) begin
      limit = (SlotW+1)'(Slots);
    end else begin
      limit = (SlotW+1)'(lim_cfg_q);
    end
  end

  always_comb begin
    held = '0;
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!valid_q[i] && (SlotW+1)'(i) < limit) begin
        free_ok = 1'b1;
        free_idx = SlotW'(i);
      end
    end
    for (int i = 0; i < Slots; i++) begin
      held = held + (SlotW+1)'(valid_q[i]);
    end
  end

  assign rd_addr = idx_q[SlotW-1:0];

  always_ff @(posedge clk_i) begin
    rd_key_q <= keys_mem[rd_addr];
    rd_cnt_q <= cnt_mem[rd_addr];
    if (mem_we) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (key_we) begin
      keys_mem[wr_idx] <= key_q;
    end
  end

  logic scan_last;
  logic rd_match;
  assign scan_last = rd_vld_q && (rd_idx_q == SlotW'(Slots - 1));
  assign rd_match = rd_vld_q && valid_q[rd_idx_q] && (rd_key_q == key_q);

  always_comb begin
    state_d = state_q;
    mem_we = 1'b0;
    key_we = 1'b0;
    wr_idx = rd_idx_q;
    wr_cnt = rd_cnt_q;
    unique case (state_q)
      StIdle: if (start) state_d = StScan;
      StScan: begin
        if (scan_last) begin
          if (cmd_q == CmdAdd) begin
            if (hit_q || rd_match) begin
              state_d = StOut;
              mem_we = 1'b1;
              wr_idx = rd_match ? rd_idx_q : hit_idx_q;
              wr_cnt = rd_match ? rd_cnt_q : hit_cnt_q;
              wr_cnt = (wr_cnt == CntMax) ? CntMax : wr_cnt + 1'b1;
            end else if (held < limit && free_ok) begin
              state_d = StOut;
              mem_we = 1'b1;
              key_we = 1'b1;
              wr_idx = free_idx;
              wr_cnt = cnt_t'(1);
            end else begin
              state_d = StDec;
            end
          end else begin
            state_d = StOut;
          end
        end
      end
      StDec: begin
        if (rd_vld_q && valid_q[rd_idx_q]) begin
          mem_we = 1'b1;
          wr_cnt = rd_cnt_q - 1'b1;
        end
        if (scan_last) state_d = StOut;
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lim_cfg_q <= CfgW'(16);
      valid_q <= '0;
      total_q <= '0;
      err_q <= '0;
      idx_q <= '0;
      rd_vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) lim_cfg_q <= cfg_data_i;
      rd_vld_q <= 1'b0;
      if (state_q == StIdle && start) begin
        idx_q <= '0;
        rd_vld_q <= 1'b1;
        hit_q <= 1'b0;
        if (cmd_i == CmdAdd && total_q != CntMax) total_q <= total_q + 1'b1;
      end else if ((state_q == StScan || state_q == StDec) && !scan_last) begin
        rd_vld_q <= 1'b1;
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == StScan && rd_match) hit_q <= 1'b1;
      if (state_q == StScan && scan_last) begin
        idx_q <= '0;
        if (state_d == StDec) begin
          rd_vld_q <= 1'b1;
          if (err_q != CntMax) err_q <= err_q + 1'b1;
        end else if (key_we) begin
          valid_q[free_idx] <= 1'b1;
        end
      end
      if (state_q == StDec && mem_we && rd_cnt_q == cnt_t'(1)) begin
        valid_q[rd_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      cmd_q <= cmd_i;
      key_q <= item_key_i;
    end
    if (rd_vld_q) rd_idx_q <= rd_addr;
    else if (state_q == StIdle) rd_idx_q <= '0;
    if (state_q == StScan && rd_match) begin
      hit_idx_q <= rd_idx_q;
      hit_cnt_q <= rd_cnt_q;
    end
    if (state_q == StScan && scan_last) begin
      lower_q <= '0;
      if (mem_we) lower_q <= wr_cnt;
      else if (cmd_q == CmdEst && rd_match) lower_q <= rd_cnt_q;
      else if (cmd_q == CmdEst && hit_q) lower_q <= hit_cnt_q;
    end
  end

  logic [CntW:0] up_sum;
  assign up_sum = {1'b0, lower_q} + {1'b0, err_q};

  assign busy = (state_q != StIdle);
  assign done = (state_q == StOut);
  assign lower_count_o = lower_q;
  assign upper_count_o = up_sum[CntW] ? CntMax : up_sum[CntW-1:0];
  assign items_seen_o = total_q;
  assign error_total_o = err_q;
endmodule

>>> hdl/fic_checker.sv
// ----------------------------------------------------------------------------
// fic_checker: port-level checks for the frequent items counter
// Watches request and result handshakes and total counters.
// ----------------------------------------------------------------------------
module fic_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] lower_count_o,
  input logic [31:0] upper_count_o,
  input logic [31:0] items_seen_o,
  input logic [31:0] error_total_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy) else $error("result while idle");
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !busy) else $error("busy after result");
  a_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (upper_count_o >= lower_count_o)) else $error("upper below lower");
  a_err_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> (error_total_o == $past(error_total_o)) &&
      (items_seen_o >= $past(items_seen_o) || items_seen_o == 32'd0))
    else $error("totals changed while idle");
endmodule

bind frequent_items_counter fic_checker u_fic_checker (.*);
